### design/fm4_pkg.sv
// Shared types, constants, routing tables and ROM contents for the
// four-operator FM channel output block. No dependencies.
`default_nettype none

package fm4_pkg;

  // Channel and register geometry.
  localparam int NUM_CHANNELS  = 3;
  localparam int REG_CHANNELS  = 3;
  localparam int LIVE_CHANNELS = (NUM_CHANNELS < REG_CHANNELS) ? NUM_CHANNELS : REG_CHANNELS;
  localparam int CH_AW         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int REG_IW        = (REG_CHANNELS > 1) ? $clog2(REG_CHANNELS) : 1;

  // Field widths.
  localparam int CHAN_W    = 2;
  localparam int PHASE_W   = 10;
  localparam int ATTEN_W   = 11;
  localparam int OPOUT_W   = 14;
  localparam int LG_W      = 13;
  localparam int SAMPLE_W  = 16;
  localparam int NUM_OPS   = 4;
  localparam int ROM_DEPTH = 256;
  localparam int ROM_AW    = 8;
  localparam int ALG_W     = 3;
  localparam int FB_W      = 3;

  // Stream packing.
  localparam int IN_FIELDS_W  = CHAN_W + NUM_OPS * (PHASE_W + ATTEN_W);
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = CHAN_W + SAMPLE_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Configuration port.
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 3;
  localparam int REG_ALG_BASE = 0;
  localparam int REG_FB_BASE  = REG_CHANNELS;

  // Pipeline depth between the accept register and the output register.
  localparam int STAGES = 9;

  localparam logic [PHASE_W-1:0] ATT_MAX = 10'h3FF;
  localparam int FB_SHIFT_BASE = 10;

  // Modulator source codes of the routing table.
  localparam logic [2:0] SRC_NONE = 3'd0;
  localparam logic [2:0] SRC_OP1  = 3'd1;
  localparam logic [2:0] SRC_OP2  = 3'd2;
  localparam logic [2:0] SRC_OP3  = 3'd3;
  localparam logic [2:0] SRC_OP12 = 3'd5;
  localparam logic [2:0] SRC_OP13 = 3'd6;
  localparam logic [2:0] SRC_OP23 = 3'd7;

  typedef logic signed [OPOUT_W-1:0] opout_t;

  typedef struct packed {
    opout_t h1;
    opout_t h0;
  } hist_t;

  typedef struct packed {
    logic             en;
    logic [CH_AW-1:0] addr;
    hist_t            data;
  } hist_wr_t;

  typedef struct packed {
    logic [CHAN_W-1:0]                 chan;
    logic                              live;
    logic [ALG_W-1:0]                  alg;
    logic [NUM_OPS-1:0][PHASE_W-1:0]   phase;
    logic [NUM_OPS-1:0][ATTEN_W-1:0]   atten;
    opout_t                            h0;
    opout_t                            op1;
    opout_t                            op2;
    opout_t                            op3;
  } ctx_t;

  localparam logic [11:0] LOGSIN_ROM [ROM_DEPTH] = '{
    12'h859,12'h6c3,12'h607,12'h58b,12'h52e,12'h4e4,12'h4a6,12'h471,
    12'h443,12'h41a,12'h3f5,12'h3d3,12'h3b5,12'h398,12'h37e,12'h365,
    12'h34e,12'h339,12'h324,12'h311,12'h2ff,12'h2ed,12'h2dc,12'h2cd,
    12'h2bd,12'h2af,12'h2a0,12'h293,12'h286,12'h279,12'h26d,12'h261,
    12'h256,12'h24b,12'h240,12'h236,12'h22c,12'h222,12'h218,12'h20f,
    12'h206,12'h1fd,12'h1f5,12'h1ec,12'h1e4,12'h1dc,12'h1d4,12'h1cd,
    12'h1c5,12'h1be,12'h1b7,12'h1b0,12'h1a9,12'h1a2,12'h19b,12'h195,
    12'h18f,12'h188,12'h182,12'h17c,12'h177,12'h171,12'h16b,12'h166,
    12'h160,12'h15b,12'h155,12'h150,12'h14b,12'h146,12'h141,12'h13c,
    12'h137,12'h133,12'h12e,12'h129,12'h125,12'h121,12'h11c,12'h118,
    12'h114,12'h10f,12'h10b,12'h107,12'h103,12'h0ff,12'h0fb,12'h0f8,
    12'h0f4,12'h0f0,12'h0ec,12'h0e9,12'h0e5,12'h0e2,12'h0de,12'h0db,
    12'h0d7,12'h0d4,12'h0d1,12'h0cd,12'h0ca,12'h0c7,12'h0c4,12'h0c1,
    12'h0be,12'h0bb,12'h0b8,12'h0b5,12'h0b2,12'h0af,12'h0ac,12'h0a9,
    12'h0a7,12'h0a4,12'h0a1,12'h09f,12'h09c,12'h099,12'h097,12'h094,
    12'h092,12'h08f,12'h08d,12'h08a,12'h088,12'h086,12'h083,12'h081,
    12'h07f,12'h07d,12'h07a,12'h078,12'h076,12'h074,12'h072,12'h070,
    12'h06e,12'h06c,12'h06a,12'h068,12'h066,12'h064,12'h062,12'h060,
    12'h05e,12'h05c,12'h05b,12'h059,12'h057,12'h055,12'h053,12'h052,
    12'h050,12'h04e,12'h04d,12'h04b,12'h04a,12'h048,12'h046,12'h045,
    12'h043,12'h042,12'h040,12'h03f,12'h03e,12'h03c,12'h03b,12'h039,
    12'h038,12'h037,12'h035,12'h034,12'h033,12'h031,12'h030,12'h02f,
    12'h02e,12'h02d,12'h02b,12'h02a,12'h029,12'h028,12'h027,12'h026,
    12'h025,12'h024,12'h023,12'h022,12'h021,12'h020,12'h01f,12'h01e,
    12'h01d,12'h01c,12'h01b,12'h01a,12'h019,12'h018,12'h017,12'h017,
    12'h016,12'h015,12'h014,12'h014,12'h013,12'h012,12'h011,12'h011,
    12'h010,12'h00f,12'h00f,12'h00e,12'h00d,12'h00d,12'h00c,12'h00c,
    12'h00b,12'h00a,12'h00a,12'h009,12'h009,12'h008,12'h008,12'h007,
    12'h007,12'h007,12'h006,12'h006,12'h005,12'h005,12'h005,12'h004,
    12'h004,12'h004,12'h003,12'h003,12'h003,12'h002,12'h002,12'h002,
    12'h002,12'h001,12'h001,12'h001,12'h001,12'h001,12'h001,12'h001,
    12'h000,12'h000,12'h000,12'h000,12'h000,12'h000,12'h000,12'h000
  };

  // Exponential table, each entry stored doubled.
  localparam logic [11:0] EXP_ROM2 [ROM_DEPTH] = '{
    12'hff4,12'hfea,12'hfde,12'hfd4,12'hfc8,12'hfbe,12'hfb4,12'hfa8,
    12'hf9e,12'hf92,12'hf88,12'hf7e,12'hf72,12'hf68,12'hf5c,12'hf52,
    12'hf48,12'hf3e,12'hf32,12'hf28,12'hf1e,12'hf14,12'hf08,12'hefe,
    12'hef4,12'heea,12'hee0,12'hed4,12'heca,12'hec0,12'heb6,12'heac,
    12'hea2,12'he98,12'he8e,12'he84,12'he7a,12'he70,12'he66,12'he5c,
    12'he52,12'he48,12'he3e,12'he34,12'he2a,12'he20,12'he16,12'he0c,
    12'he04,12'hdfa,12'hdf0,12'hde6,12'hddc,12'hdd2,12'hdca,12'hdc0,
    12'hdb6,12'hdac,12'hda4,12'hd9a,12'hd90,12'hd88,12'hd7e,12'hd74,
    12'hd6a,12'hd62,12'hd58,12'hd50,12'hd46,12'hd3c,12'hd34,12'hd2a,
    12'hd22,12'hd18,12'hd10,12'hd06,12'hcfe,12'hcf4,12'hcec,12'hce2,
    12'hcda,12'hcd0,12'hcc8,12'hcbe,12'hcb6,12'hcae,12'hca4,12'hc9c,
    12'hc92,12'hc8a,12'hc82,12'hc78,12'hc70,12'hc68,12'hc60,12'hc56,
    12'hc4e,12'hc46,12'hc3c,12'hc34,12'hc2c,12'hc24,12'hc1c,12'hc12,
    12'hc0a,12'hc02,12'hbfa,12'hbf2,12'hbea,12'hbe0,12'hbd8,12'hbd0,
    12'hbc8,12'hbc0,12'hbb8,12'hbb0,12'hba8,12'hba0,12'hb98,12'hb90,
    12'hb88,12'hb80,12'hb78,12'hb70,12'hb68,12'hb60,12'hb58,12'hb50,
    12'hb48,12'hb40,12'hb38,12'hb32,12'hb2a,12'hb22,12'hb1a,12'hb12,
    12'hb0a,12'hb02,12'hafc,12'haf4,12'haec,12'hae4,12'hade,12'had6,
    12'hace,12'hac6,12'hac0,12'hab8,12'hab0,12'haa8,12'haa2,12'ha9a,
    12'ha92,12'ha8c,12'ha84,12'ha7c,12'ha76,12'ha6e,12'ha68,12'ha60,
    12'ha58,12'ha52,12'ha4a,12'ha44,12'ha3c,12'ha36,12'ha2e,12'ha28,
    12'ha20,12'ha18,12'ha12,12'ha0c,12'ha04,12'h9fe,12'h9f6,12'h9f0,
    12'h9e8,12'h9e2,12'h9da,12'h9d4,12'h9ce,12'h9c6,12'h9c0,12'h9b8,
    12'h9b2,12'h9ac,12'h9a4,12'h99e,12'h998,12'h990,12'h98a,12'h984,
    12'h97c,12'h976,12'h970,12'h96a,12'h962,12'h95c,12'h956,12'h950,
    12'h948,12'h942,12'h93c,12'h936,12'h930,12'h928,12'h922,12'h91c,
    12'h916,12'h910,12'h90a,12'h904,12'h8fc,12'h8f6,12'h8f0,12'h8ea,
    12'h8e4,12'h8de,12'h8d8,12'h8d2,12'h8cc,12'h8c6,12'h8c0,12'h8ba,
    12'h8b4,12'h8ae,12'h8a8,12'h8a2,12'h89c,12'h896,12'h890,12'h88a,
    12'h884,12'h87e,12'h878,12'h872,12'h86c,12'h866,12'h860,12'h85a,
    12'h854,12'h850,12'h84a,12'h844,12'h83e,12'h838,12'h832,12'h82c,
    12'h828,12'h822,12'h81c,12'h816,12'h810,12'h80c,12'h806,12'h800
  };

  function automatic logic [11:0] logsin(input logic [ROM_AW-1:0] q);
    return LOGSIN_ROM[q];
  endfunction

  function automatic logic [10:0] exp_lin(input logic [ROM_AW-1:0] q);
    logic [11:0] e;
    e = EXP_ROM2[q];
    return e[11:1];
  endfunction

  // Modulator source of operator two, three and four for each algorithm.
  function automatic logic [2:0] mod_src2(input logic [ALG_W-1:0] alg);
    logic [2:0] s;
    unique case (alg)
      3'd1, 3'd2, 3'd7: s = SRC_NONE;
      default:          s = SRC_OP1;
    endcase
    return s;
  endfunction

  function automatic logic [2:0] mod_src3(input logic [ALG_W-1:0] alg);
    logic [2:0] s;
    unique case (alg)
      3'd0:    s = SRC_OP2;
      3'd1:    s = SRC_OP12;
      3'd2:    s = SRC_OP2;
      3'd5:    s = SRC_OP1;
      default: s = SRC_NONE;
    endcase
    return s;
  endfunction

  function automatic logic [2:0] mod_src4(input logic [ALG_W-1:0] alg);
    logic [2:0] s;
    unique case (alg)
      3'd0, 3'd1, 3'd4: s = SRC_OP3;
      3'd2:             s = SRC_OP13;
      3'd3:             s = SRC_OP23;
      3'd5:             s = SRC_OP1;
      default:          s = SRC_NONE;
    endcase
    return s;
  endfunction

  // Which of operators one..three (bit 0..2) join operator four in the sum.
  function automatic logic [2:0] sum_mask(input logic [ALG_W-1:0] alg);
    logic [2:0] m;
    unique case (alg)
      3'd4:       m = 3'b010;
      3'd5, 3'd6: m = 3'b110;
      3'd7:       m = 3'b111;
      default:    m = 3'b000;
    endcase
    return m;
  endfunction

  // Phase modulation: the selected value halved, rounded down, kept to 10 bits.
  function automatic logic [PHASE_W-1:0] mod_sel(input logic [2:0] code, input opout_t o1,
                                                 input opout_t o2, input opout_t o3);
    logic signed [OPOUT_W:0] s;
    unique case (code)
      SRC_OP1:  s = (OPOUT_W+1)'(o1);
      SRC_OP2:  s = (OPOUT_W+1)'(o2);
      SRC_OP3:  s = (OPOUT_W+1)'(o3);
      SRC_OP12: s = (OPOUT_W+1)'(o1) + (OPOUT_W+1)'(o2);
      SRC_OP13: s = (OPOUT_W+1)'(o1) + (OPOUT_W+1)'(o3);
      SRC_OP23: s = (OPOUT_W+1)'(o2) + (OPOUT_W+1)'(o3);
      default:  s = '0;
    endcase
    return s[PHASE_W:1];
  endfunction

endpackage

`default_nettype wire

### design/fm4_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module fm4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### design/fm4_hist.sv
// Operator one output history per channel: RAM, reset-valid bits and the
// feedback modulation derived from the last two outputs. Uses fm4_pkg, fm4_ram.
`default_nettype none

module fm4_hist
  import fm4_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             rd_en,
  input  wire logic [CH_AW-1:0] rd_addr,
  input  wire logic [FB_W-1:0]  fb_depth,
  input  wire hist_wr_t         wr,
  output opout_t                h0,
  output logic [PHASE_W-1:0]    fb_mod
);

  logic [$bits(hist_t)-1:0] rd_bits;
  logic [NUM_CHANNELS-1:0]  hvalid_r;
  logic                     rv_r;
  hist_t                    cur;
  logic signed [OPOUT_W:0]  hsum;
  logic signed [OPOUT_W:0]  fbv;
  logic [3:0]               shamt;

  fm4_ram #(
    .WIDTH($bits(hist_t)),
    .DEPTH(NUM_CHANNELS)
  ) u_ram (
    .clk  (clk),
    .we   (wr.en),
    .waddr(wr.addr),
    .wdata(wr.data),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(rd_bits)
  );

  // An entry never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hvalid_r <= '0;
      rv_r     <= 1'b0;
    end else begin
      if (wr.en) begin
        hvalid_r[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        rv_r <= hvalid_r[rd_addr];
      end
    end
  end

  always_comb begin
    cur    = rv_r ? hist_t'(rd_bits) : '0;
    hsum   = (OPOUT_W+1)'(cur.h0) + (OPOUT_W+1)'(cur.h1);
    shamt  = 4'(FB_SHIFT_BASE) - {1'b0, fb_depth};
    fbv    = hsum >>> shamt;
    fb_mod = (fb_depth == '0) ? '0 : fbv[PHASE_W-1:0];
    h0     = cur.h0;
  end

endmodule

`default_nettype wire

### design/fm4_op.sv
// One FM operator as two register stages: log-sine lookup plus attenuation,
// then exponential lookup, shift and sign. Uses fm4_pkg.
`default_nettype none

module fm4_op
  import fm4_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               en_a,
  input  wire logic               en_b,
  input  wire logic [PHASE_W-1:0] phase,
  input  wire logic [PHASE_W-1:0] mod,
  input  wire logic [ATTEN_W-1:0] atten,
  output opout_t                  op_out
);

  logic [PHASE_W-1:0] ph;
  logic [ROM_AW-1:0]  q;
  logic [PHASE_W-1:0] att_c;
  logic [LG_W-1:0]    lg_nxt;
  logic [LG_W-1:0]    lg_r;
  logic               neg_r;
  logic [LG_W-1:0]    mag;
  opout_t             op_nxt;
  opout_t             op_r;

  // First half: the quarter wave is mirrored on the odd quarters.
  always_comb begin
    ph     = phase + mod;
    q      = ph[8] ? ~ph[ROM_AW-1:0] : ph[ROM_AW-1:0];
    att_c  = atten[ATTEN_W-1] ? ATT_MAX : atten[PHASE_W-1:0];
    lg_nxt = LG_W'(logsin(q)) + {1'b0, att_c, 2'b00};
  end

  // Second half: the upper log bits are the right shift of the mantissa.
  always_comb begin
    mag    = {exp_lin(lg_r[ROM_AW-1:0]), 2'b00} >> lg_r[LG_W-1:ROM_AW];
    op_nxt = neg_r ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      lg_r  <= lg_nxt;
      neg_r <= ph[PHASE_W-1];
    end
    if (en_b) begin
      op_r <= op_nxt;
    end
  end

  assign op_out = op_r;

endmodule

`default_nettype wire

### design/fm_four_operator_channel_output.sv
// Top level of the four-operator FM channel output block.
// Uses fm4_pkg, fm4_hist (history RAM) and fm4_op (operator stages).
`default_nettype none

// Usage
//   in_*  : one transfer carries one channel's four operator phases and
//           attenuations; a result transfer on out_* follows for every input,
//           in order, carrying the channel number and the signed 16-bit sample.
//   cfg_* : algorithm (index 0..2) and operator one feedback depth (index 3..5)
//           per channel; a write lands on any edge with cfg_we high. Write only
//           while no item is in flight. Indexes beyond 5 are ignored.
// Throughput: one item per cycle while the output is not stalled and each
//   item names a channel other than those of the three items before it.
//   Operator one's output history lives in a RAM that is read at accept and
//   written back three stages later; an item whose channel is still in that
//   read-modify-write window is held off until the earlier item leaves it.
// Channel numbers without registers pass through with a zero sample and leave
//   the history untouched.
// Reset clears the configuration, the pipeline and the history (through a
//   valid bit per channel, no clearing pass is needed).
// Stall: when out_tready is low the result waits in the output register and
//   each pipeline stage keeps filling while it has a free slot, so input
//   transfers continue until the pipeline is full.
module fm_four_operator_channel_output
  import fm4_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // Fields from bit 0 up: chan_sel[2], phase_op1..phase_op4[10 each],
  // atten_op1..atten_op4[11 each], zero fill.
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // Fields from bit 0 up: chan_out[2], sample[16], zero fill.
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int PH_BASE = CHAN_W;
  localparam int AT_BASE = CHAN_W + NUM_OPS * PHASE_W;
  localparam logic signed [SAMPLE_W:0] SAT_MAX = 17'sd32767;
  localparam logic signed [SAMPLE_W:0] SAT_MIN = -17'sd32768;

  // Configuration registers.
  logic [ALG_W-1:0] alg_r [REG_CHANNELS];
  logic [FB_W-1:0]  fb_r  [REG_CHANNELS];

  // Pipeline.
  logic [STAGES:1]   v_r;
  ctx_t              ctx_r   [1:STAGES];
  ctx_t              ctx_nxt [1:STAGES];
  logic [STAGES+1:1] rdy;

  // Input decode.
  logic [CHAN_W-1:0] in_chan;
  logic              in_live;
  logic              in_accept;
  logic              hazard;

  // History unit.
  logic              hist_rd_en;
  logic [CH_AW-1:0]  hist_rd_addr;
  logic [FB_W-1:0]   fb_depth;
  opout_t            hist_h0;
  logic [PHASE_W-1:0] fb_mod;
  hist_wr_t          hist_wr;

  // Operators.
  logic [PHASE_W-1:0] op_phase [NUM_OPS];
  logic [PHASE_W-1:0] op_mod   [NUM_OPS];
  logic [ATTEN_W-1:0] op_atten [NUM_OPS];
  opout_t             op_out   [NUM_OPS];

  // Output register.
  logic                out_valid_r;
  logic [CHAN_W-1:0]   out_chan_r;
  logic [SAMPLE_W-1:0] out_sample_r;
  logic [SAMPLE_W-1:0] sample_nxt;
  logic signed [SAMPLE_W:0] sum;
  logic [2:0]          smask;
  logic                same_chan_inflight;

  // ---------------------------------------------------------------------------
  // Configuration writes. Values are three bits wide; out-of-range indexes
  // fall through both branches.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REG_CHANNELS; i++) begin
        alg_r[i] <= '0;
        fb_r[i]  <= '0;
      end
    end else if (cfg_we) begin
      priority if (int'(cfg_index) < REG_FB_BASE) begin
        alg_r[REG_IW'(cfg_index - CFG_IDX_W'(REG_ALG_BASE))] <= cfg_wdata;
      end else if (int'(cfg_index) < REG_FB_BASE + REG_CHANNELS) begin
        fb_r[REG_IW'(cfg_index - CFG_IDX_W'(REG_FB_BASE))] <= cfg_wdata;
      end else begin
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake. Each stage takes a new item when it is empty or its content
  // moves on; the output register parts the result side from the pipeline.
  // ---------------------------------------------------------------------------
  always_comb begin
    rdy[STAGES+1] = !out_valid_r || out_tready;
    for (int i = STAGES; i >= 1; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
  end

  assign in_chan = in_tdata[CHAN_W-1:0];
  assign in_live = int'(in_chan) < LIVE_CHANNELS;

  // Interlock: the history entry of a channel is in flight from the RAM read
  // at accept until the write-back as the item leaves stage three.
  always_comb begin
    hazard = 1'b0;
    for (int s = 1; s <= 3; s++) begin
      if (v_r[s] && ctx_r[s].live && ctx_r[s].chan == in_chan) begin
        hazard = 1'b1;
      end
    end
  end

  assign in_tready = rdy[1] && !hazard;
  assign in_accept = in_tvalid && in_tready;

  // ---------------------------------------------------------------------------
  // Stage contents. Operator results join the item context as they leave
  // their operator's output register.
  // ---------------------------------------------------------------------------
  always_comb begin
    ctx_nxt[1].chan = in_chan;
    ctx_nxt[1].live = in_live;
    ctx_nxt[1].alg  = in_live ? alg_r[in_chan[REG_IW-1:0]] : '0;
    for (int g = 0; g < NUM_OPS; g++) begin
      ctx_nxt[1].phase[g] = in_tdata[PH_BASE + g*PHASE_W +: PHASE_W];
      ctx_nxt[1].atten[g] = in_tdata[AT_BASE + g*ATTEN_W +: ATTEN_W];
    end
    ctx_nxt[1].h0  = '0;
    ctx_nxt[1].op1 = '0;
    ctx_nxt[1].op2 = '0;
    ctx_nxt[1].op3 = '0;

    for (int i = 2; i <= STAGES; i++) begin
      ctx_nxt[i] = ctx_r[i-1];
    end
    ctx_nxt[2].h0  = hist_h0;
    ctx_nxt[4].op1 = op_out[0];
    ctx_nxt[6].op2 = op_out[1];
    ctx_nxt[8].op3 = op_out[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[1]) begin
        v_r[1] <= in_accept;
      end
      for (int i = 2; i <= STAGES; i++) begin
        if (rdy[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 1; i <= STAGES; i++) begin
      if (rdy[i]) begin
        ctx_r[i] <= ctx_nxt[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // History read at accept, feedback computed in stage one, write-back of the
  // new operator one output when the item leaves stage three.
  // ---------------------------------------------------------------------------
  assign hist_rd_en   = in_accept && in_live;
  assign hist_rd_addr = CH_AW'(in_chan);
  assign fb_depth     = ctx_r[1].live ? fb_r[ctx_r[1].chan[REG_IW-1:0]] : '0;

  always_comb begin
    hist_wr.en      = v_r[3] && rdy[4] && ctx_r[3].live;
    hist_wr.addr    = CH_AW'(ctx_r[3].chan);
    hist_wr.data.h1 = ctx_r[3].h0;
    hist_wr.data.h0 = op_out[0];
  end

  fm4_hist u_hist (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (hist_rd_en),
    .rd_addr (hist_rd_addr),
    .fb_depth(fb_depth),
    .wr      (hist_wr),
    .h0      (hist_h0),
    .fb_mod  (fb_mod)
  );

  // ---------------------------------------------------------------------------
  // Operators one to four, each two stages, chained in that order so every
  // modulator is ready before the operator that needs it.
  // ---------------------------------------------------------------------------
  always_comb begin
    op_phase[0] = ctx_r[1].phase[0];
    op_atten[0] = ctx_r[1].atten[0];
    op_mod[0]   = fb_mod;

    op_phase[1] = ctx_r[3].phase[1];
    op_atten[1] = ctx_r[3].atten[1];
    op_mod[1]   = mod_sel(mod_src2(ctx_r[3].alg), op_out[0], '0, '0);

    op_phase[2] = ctx_r[5].phase[2];
    op_atten[2] = ctx_r[5].atten[2];
    op_mod[2]   = mod_sel(mod_src3(ctx_r[5].alg), ctx_r[5].op1, op_out[1], '0);

    op_phase[3] = ctx_r[7].phase[3];
    op_atten[3] = ctx_r[7].atten[3];
    op_mod[3]   = mod_sel(mod_src4(ctx_r[7].alg), ctx_r[7].op1, ctx_r[7].op2, op_out[2]);
  end

  for (genvar g = 0; g < NUM_OPS; g++) begin : g_op
    fm4_op u_op (
      .clk   (clk),
      .en_a  (rdy[2*g + 2]),
      .en_b  (rdy[2*g + 3]),
      .phase (op_phase[g]),
      .mod   (op_mod[g]),
      .atten (op_atten[g]),
      .op_out(op_out[g])
    );
  end

  // ---------------------------------------------------------------------------
  // Output mix and saturation.
  // ---------------------------------------------------------------------------
  always_comb begin
    smask = sum_mask(ctx_r[STAGES].alg);
    sum   = (SAMPLE_W+1)'(op_out[3])
          + (smask[0] ? (SAMPLE_W+1)'(ctx_r[STAGES].op1) : '0)
          + (smask[1] ? (SAMPLE_W+1)'(ctx_r[STAGES].op2) : '0)
          + (smask[2] ? (SAMPLE_W+1)'(ctx_r[STAGES].op3) : '0);
    priority if (!ctx_r[STAGES].live) begin
      sample_nxt = '0;
    end else if (sum > SAT_MAX) begin
      sample_nxt = SAT_MAX[SAMPLE_W-1:0];
    end else if (sum < SAT_MIN) begin
      sample_nxt = SAT_MIN[SAMPLE_W-1:0];
    end else begin
      sample_nxt = sum[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy[STAGES+1]) begin
      out_valid_r <= v_r[STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[STAGES+1]) begin
      out_chan_r   <= ctx_r[STAGES].chan;
      out_sample_r <= sample_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - OUT_FIELDS_W)'(0), out_sample_r, out_chan_r};

  // ---------------------------------------------------------------------------
  // Checks.
  // ---------------------------------------------------------------------------
  always_comb begin
    same_chan_inflight =
        (v_r[1] && v_r[2] && ctx_r[1].live && ctx_r[2].live && ctx_r[1].chan == ctx_r[2].chan)
     || (v_r[1] && v_r[3] && ctx_r[1].live && ctx_r[3].live && ctx_r[1].chan == ctx_r[3].chan)
     || (v_r[2] && v_r[3] && ctx_r[2].live && ctx_r[3].live && ctx_r[2].chan == ctx_r[3].chan);
  end

  a_one_rmw_per_chan: assert property (@(posedge clk) disable iff (!rst_n)
    !same_chan_inflight)
    else $error("two items of one channel inside the history window");

  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (hist_wr.en && hist_rd_en) |-> hist_wr.addr != hist_rd_addr)
    else $error("history read and write-back hit the same entry");

  a_accept_fills_stage1: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> v_r[1])
    else $error("accepted transfer did not enter the pipeline");

  a_dead_chan_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && int'(out_chan_r) >= LIVE_CHANNELS) |-> out_sample_r == '0)
    else $error("channel without registers produced a nonzero sample");

endmodule

`default_nettype wire

### sim/fm_four_operator_channel_output_tb.sv
// Self-checking testbench for the four-operator FM channel output block.
// Depends on fm4_pkg and the RTL of fm_four_operator_channel_output only; a small
// sample scoreboard predicts every channel sample from its own tables and routing copy.
`default_nettype none

module fm_four_operator_channel_output_tb
  import fm4_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Layout of one input transfer, lowest field in the lowest bits.
  typedef struct packed {
    logic [1:0]       fill;
    logic [3:0][10:0] atten;   // atten[0] belongs to operator one
    logic [3:0][9:0]  phase;   // phase[0] belongs to operator one
    logic [1:0]       chan;
  } op_item_t;

  // Layout of one result transfer.
  typedef struct packed {
    logic [5:0]        fill;
    logic signed [15:0] sample;
    logic [1:0]        chan;
  } sample_t;

  // The eight operator connection schemes, by register value.
  typedef enum logic [2:0] {
    ALG_SERIAL          = 3'd0,
    ALG_OP12_INTO_3     = 3'd1,
    ALG_OP1_AND_CHAIN23 = 3'd2,
    ALG_CHAIN12_AND_3   = 3'd3,
    ALG_TWIN_STACKS     = 3'd4,
    ALG_OP1_FANOUT      = 3'd5,
    ALG_STACK_PLUS_TWO  = 3'd6,
    ALG_ADDITIVE        = 3'd7
  } algo_t;

  // Register map of the configuration port.
  localparam logic [CFG_IDX_W-1:0] IDX_ALG_BASE = CFG_IDX_W'(REG_ALG_BASE);
  localparam logic [CFG_IDX_W-1:0] IDX_FB_BASE  = CFG_IDX_W'(REG_FB_BASE);
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;
  localparam logic [2:0]           FB_OFF       = 3'd0;
  localparam logic [2:0]           FB_DEEPEST   = 3'd7;

  localparam logic [1:0] CHAN_NO_REGS = 2'd3;
  localparam real        PI           = 3.14159265358979323846;
  localparam int         MAX_REPORTS  = 40;
  localparam int         HOLD_CYCLES  = 150;
  localparam int         DRAIN_SLACK  = 30;

  // Keeps its own copy of the channel registers and the operator one history,
  // turns every accepted input into the sample it must produce, and compares.
  class sample_scoreboard;
    int unsigned logsin_tab[256];
    int unsigned exp_tab[256];
    logic [2:0]  alg_reg[REG_CHANNELS];
    logic [2:0]  fb_depth[REG_CHANNELS];
    int          op1_last[REG_CHANNELS];
    int          op1_prev[REG_CHANNELS];
    sample_t     expected_samples[$];
    int          errors;
    int          inputs;
    int          checked;
    int          unused_seen;
    logic [7:0]  algs_used;
    logic [7:0]  depths_used;

    function new();
      real a;
      int  i;
      // Build both tables straight from their defining formulas.
      for (i = 0; i < 256; i++) begin
        a = (2.0 * i + 1.0) / 512.0 * PI / 2.0;
        logsin_tab[i] = $rtoi($floor(-$ln($sin(a)) / $ln(2.0) * 256.0 + 0.5));
        exp_tab[i] = $rtoi($floor($pow(2.0, -(i + 1.0) / 256.0) * 2048.0 + 0.5));
      end
      for (i = 0; i < REG_CHANNELS; i++) begin
        alg_reg[i] = '0;
        fb_depth[i] = '0;
        op1_last[i] = 0;
        op1_prev[i] = 0;
      end
      errors = 0;
      inputs = 0;
      checked = 0;
      unused_seen = 0;
      algs_used = '0;
      depths_used = '0;
    endfunction

    function void note_config(logic [CFG_IDX_W-1:0] idx, logic [2:0] val);
      if (idx < IDX_FB_BASE)
        alg_reg[idx - IDX_ALG_BASE] = val;
      else if (idx < IDX_FB_BASE + REG_CHANNELS)
        fb_depth[idx - IDX_FB_BASE] = val;
    endfunction

    // One operator: log-sine lookup plus attenuation, then back to linear.
    function int op_level(logic [9:0] phase, logic [9:0] pm, logic [10:0] atten);
      logic [9:0]  ph;
      logic [7:0]  q;
      int unsigned att;
      int unsigned lg;
      int unsigned mag;
      att = (atten > 11'd1023) ? 1023 : atten;
      ph = phase + pm;
      q = ph[8] ? ~ph[7:0] : ph[7:0];
      lg = (logsin_tab[q] + (att << 2)) & 32'h1FFF;
      mag = (exp_tab[lg & 32'hFF] << 2) >> (lg >> 8);
      return ph[9] ? -int'(mag) : int'(mag);
    endfunction

    // A modulator enters the phase halved, rounded toward minus infinity.
    function logic [9:0] half_mod(int v);
      int h;
      h = v >>> 1;
      return h[9:0];
    endfunction

    function int pick_source(logic [2:0] code, int o1, int o2, int o3);
      case (code)
        SRC_OP1:  return o1;
        SRC_OP2:  return o2;
        SRC_OP3:  return o3;
        SRC_OP12: return o1 + o2;
        SRC_OP13: return o1 + o3;
        SRC_OP23: return o2 + o3;
        default:  return 0;
      endcase
    endfunction

    function int clamp16(int v);
      if (v < -32768) return -32768;
      if (v > 32767) return 32767;
      return v;
    endfunction

    // Modulators of operators two, three, four and the operators summed with four.
    function void route(algo_t a, output logic [2:0] m2, output logic [2:0] m3,
                        output logic [2:0] m4, output logic [2:0] sum_ops);
      case (a)
        ALG_SERIAL: begin
          m2 = SRC_OP1;  m3 = SRC_OP2;  m4 = SRC_OP3;  sum_ops = 3'b000;
        end
        ALG_OP12_INTO_3: begin
          m2 = SRC_NONE; m3 = SRC_OP12; m4 = SRC_OP3;  sum_ops = 3'b000;
        end
        ALG_OP1_AND_CHAIN23: begin
          m2 = SRC_NONE; m3 = SRC_OP2;  m4 = SRC_OP13; sum_ops = 3'b000;
        end
        ALG_CHAIN12_AND_3: begin
          m2 = SRC_OP1;  m3 = SRC_NONE; m4 = SRC_OP23; sum_ops = 3'b000;
        end
        ALG_TWIN_STACKS: begin
          m2 = SRC_OP1;  m3 = SRC_NONE; m4 = SRC_OP3;  sum_ops = 3'b010;
        end
        ALG_OP1_FANOUT: begin
          m2 = SRC_OP1;  m3 = SRC_OP1;  m4 = SRC_OP1;  sum_ops = 3'b110;
        end
        ALG_STACK_PLUS_TWO: begin
          m2 = SRC_OP1;  m3 = SRC_NONE; m4 = SRC_NONE; sum_ops = 3'b110;
        end
        default: begin
          m2 = SRC_NONE; m3 = SRC_NONE; m4 = SRC_NONE; sum_ops = 3'b111;
        end
      endcase
    endfunction

    function sample_t predict_sample(op_item_t it);
      sample_t    r;
      algo_t      a;
      int         ch;
      int         o1;
      int         o2;
      int         o3;
      int         acc;
      int         fb_sum;
      logic [9:0] fb_mod;
      logic [2:0] m2;
      logic [2:0] m3;
      logic [2:0] m4;
      logic [2:0] sum_ops;
      r = '0;
      r.chan = it.chan;
      // A channel number without registers passes through with silence.
      if (it.chan >= REG_CHANNELS || it.chan >= NUM_CHANNELS) begin
        unused_seen++;
        return r;
      end
      ch = it.chan;
      a = algo_t'(alg_reg[ch]);
      algs_used[a] = 1'b1;
      depths_used[fb_depth[ch]] = 1'b1;
      fb_mod = '0;
      if (fb_depth[ch] != FB_OFF) begin
        fb_sum = (op1_last[ch] + op1_prev[ch]) >>> (10 - fb_depth[ch]);
        fb_mod = fb_sum[9:0];
      end
      o1 = op_level(it.phase[0], fb_mod, it.atten[0]);
      op1_prev[ch] = op1_last[ch];
      op1_last[ch] = o1;
      route(a, m2, m3, m4, sum_ops);
      o2 = op_level(it.phase[1], half_mod(pick_source(m2, o1, 0, 0)), it.atten[1]);
      o3 = op_level(it.phase[2], half_mod(pick_source(m3, o1, o2, 0)), it.atten[2]);
      acc = op_level(it.phase[3], half_mod(pick_source(m4, o1, o2, o3)), it.atten[3]);
      if (sum_ops[0]) acc = clamp16(acc + o1);
      if (sum_ops[1]) acc = clamp16(acc + o2);
      if (sum_ops[2]) acc = clamp16(acc + o3);
      r.sample = acc[15:0];
      return r;
    endfunction

    function void note_input(op_item_t it);
      sample_t want;
      inputs++;
      want = predict_sample(it);
      expected_samples = {expected_samples, want};
    endfunction

    function void check_result(sample_t got);
      sample_t want;
      if (expected_samples.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%t: unexpected sample, expected none, got chan %0d sample %0d",
                   $time, got.chan, $signed(got.sample));
        return;
      end
      want = expected_samples.pop_front();
      checked++;
      if (got.chan !== want.chan) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%t: channel mismatch, expected %0d, got %0d",
                   $time, want.chan, got.chan);
      end
      if (got.sample !== want.sample) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%t: sample mismatch on channel %0d, expected %0d, got %0d",
                   $time, want.chan, $signed(want.sample), $signed(got.sample));
      end
      if (got.fill !== want.fill) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%t: fill bits mismatch, expected %h, got %h",
                   $time, want.fill, got.fill);
      end
    endfunction

    function void close_out();
      if (expected_samples.size() != 0) begin
        errors += expected_samples.size();
        $display("%t: %0d expected samples never arrived, expected chan %0d sample %0d first",
                 $time, expected_samples.size(), expected_samples[0].chan,
                 $signed(expected_samples[0].sample));
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset and the signals toward the block. Every input starts known.
  // ---------------------------------------------------------------------------
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Idle percentages for both sides; the sender's is used by send_item and the
  // receiver's by the ready process below.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  // The long receiver hold is requested by bumping hold_tag; the ready process
  // notices the change and counts the hold out on its own.
  logic [7:0] hold_tag = '0;
  logic [7:0] hold_seen = '0;
  int         hold_left = 0;

  int cfg_round = 0;

  sample_scoreboard sb;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  fm_four_operator_channel_output uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // Result side: out_tready is redrawn every cycle, except during the long hold,
  // where it stays low so the pipeline fills and in_tready has to drop.
  always @(posedge clk) begin
    if (hold_tag != hold_seen) begin
      hold_seen <= hold_tag;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Every result transfer is checked against the oldest prediction. The values
  // sampled here are the ones present before the edge, which is when the
  // handshake took place.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(sample_t'(out_tdata));
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #3_000_000;
    $display("Timed out waiting for the block");
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driving tasks.
  // ---------------------------------------------------------------------------

  // Offers one item and returns right after the edge that accepted it. While
  // the sender idles, in_tvalid is low and tdata carries junk that must be
  // ignored. A valid that stays high into the next item is left alone here.
  task automatic send_item(input op_item_t it);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 12) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      in_tdata <= IN_TDATA_W'({$urandom(), $urandom(), $urandom()});
      repeat (gap) @(posedge clk);
    end
    in_tdata <= IN_TDATA_W'(it);
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(it);
  endtask

  // Drops valid and waits until every predicted sample has come back. Each input
  // produces exactly one sample, so the block is idle once the queue is empty.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.expected_samples.size() != 0);
  endtask

  // Writes all six channel registers, one per cycle, and sometimes one of the
  // unmapped indexes as well, which the block must ignore.
  task automatic set_channels(input logic [2:0] alg0, input logic [2:0] alg1,
                              input logic [2:0] alg2, input logic [2:0] fb0,
                              input logic [2:0] fb1, input logic [2:0] fb2,
                              input bit poke_spare);
    logic [2:0] vals [6];
    int         i;
    vals = '{alg0, alg1, alg2, fb0, fb1, fb2};
    for (i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= (i < REG_CHANNELS) ? IDX_ALG_BASE + CFG_IDX_W'(i)
                                      : IDX_FB_BASE + CFG_IDX_W'(i - REG_CHANNELS);
      cfg_wdata <= vals[i];
      @(posedge clk);
      sb.note_config((i < REG_CHANNELS) ? IDX_ALG_BASE + CFG_IDX_W'(i)
                                        : IDX_FB_BASE + CFG_IDX_W'(i - REG_CHANNELS),
                     vals[i]);
    end
    if (poke_spare) begin
      cfg_we <= 1'b1;
      cfg_index <= $urandom_range(1) ? IDX_SPARE_HI : IDX_SPARE_LO;
      cfg_wdata <= CFG_DATA_W'($urandom_range(7));
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
  endtask

  function automatic op_item_t uniform_item(logic [1:0] chan, logic [9:0] ph, logic [10:0] at);
    op_item_t it;
    it = '0;
    it.chan = chan;
    it.phase = {4{ph}};
    it.atten = {4{at}};
    return it;
  endfunction

  // Random item. Channels repeat often to hit the history hazard window, the
  // channel without registers shows up now and then, and attenuation leans
  // toward small values so that modulation and feedback actually matter.
  function automatic op_item_t random_item(logic [1:0] last_ch);
    op_item_t    it;
    int unsigned pick;
    int          i;
    it = '0;
    pick = $urandom_range(15);
    if (pick < 6) it.chan = last_ch;
    else if (pick == 15) it.chan = CHAN_NO_REGS;
    else it.chan = 2'($urandom_range(2));
    for (i = 0; i < 4; i++) begin
      it.phase[i] = 10'($urandom_range(1023));
      case ($urandom_range(9))
        6:       it.atten[i] = 11'($urandom_range(2047));
        7:       it.atten[i] = 11'd1023;
        8:       it.atten[i] = 11'd1024;
        9:       it.atten[i] = 11'($urandom_range(1023, 256));
        default: it.atten[i] = 11'($urandom_range(255));
      endcase
    end
    return it;
  endfunction

  // One random phase: the registers change every 70 items, the first two
  // settings of the whole run being all at the top and all at zero; optionally
  // the receiver holds off once halfway through.
  task automatic run_phase(input int unsigned snd_pct, input int unsigned rcv_pct,
                           input int n_items, input bit with_hold);
    op_item_t   it;
    logic [1:0] last_ch;
    int         k;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    last_ch = '0;
    for (k = 0; k < n_items; k++) begin
      if (k % 70 == 0) begin
        wait_idle();
        if (cfg_round == 0)
          set_channels(ALG_ADDITIVE, ALG_ADDITIVE, ALG_ADDITIVE,
                       FB_DEEPEST, FB_DEEPEST, FB_DEEPEST, 1'b1);
        else if (cfg_round == 1)
          set_channels(ALG_SERIAL, ALG_SERIAL, ALG_SERIAL, FB_OFF, FB_OFF, FB_OFF, 1'b0);
        else
          set_channels(3'($urandom_range(7)), 3'($urandom_range(7)), 3'($urandom_range(7)),
                       3'($urandom_range(7)), 3'($urandom_range(7)), 3'($urandom_range(7)),
                       $urandom_range(3) == 0);
        cfg_round++;
      end
      if (with_hold && k == n_items / 2)
        hold_tag <= hold_tag + 8'd1;
      it = random_item(last_ch);
      last_ch = it.chan;
      send_item(it);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    op_item_t it;
    int       i;
    sb = new();
    recv_idle_pct = 20;

    // Synchronous reset held from the start, then released once.
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, reset settings first (serial chain, no feedback): all
    // zero, phases at the top, the quadrant boundary with the largest
    // attenuation that still counts, attenuation just past the clamp and at its
    // maximum, the channel without registers, and the end of the third quadrant.
    send_item(uniform_item(2'd0, 10'd0, 11'd0));
    send_item(uniform_item(2'd1, 10'd1023, 11'd0));
    send_item(uniform_item(2'd2, 10'h100, 11'd1023));
    send_item(uniform_item(2'd0, 10'h200, 11'd1024));
    send_item(uniform_item(2'd1, 10'h0FF, 11'd2047));
    it = random_item(CHAN_NO_REGS);
    it.chan = CHAN_NO_REGS;
    send_item(it);
    send_item(uniform_item(2'd2, 10'h2FF, 11'd0));

    // Additive, one stack plus two, op1 fanning out; deepest, shallowest and a
    // middle feedback depth. Repeated items on one channel build up feedback,
    // and the channel without registers must leave that history alone.
    wait_idle();
    set_channels(ALG_ADDITIVE, ALG_STACK_PLUS_TWO, ALG_OP1_FANOUT,
                 FB_DEEPEST, 3'd1, 3'd4, 1'b1);
    for (i = 0; i < 8; i++) begin
      it = random_item(2'd0);
      it.chan = (i < 3) ? 2'd0 : (i == 5) ? CHAN_NO_REGS : 2'(1 + (i % 2));
      it.atten = '0;
      send_item(it);
    end

    wait_idle();
    set_channels(ALG_TWIN_STACKS, ALG_CHAIN12_AND_3, ALG_OP1_AND_CHAIN23,
                 3'd3, FB_OFF, FB_DEEPEST, 1'b0);
    for (i = 0; i < 6; i++) begin
      it = random_item(2'd0);
      it.chan = 2'(i % 3);
      send_item(it);
    end

    wait_idle();
    set_channels(ALG_OP12_INTO_3, ALG_SERIAL, ALG_ADDITIVE, 3'd5, 3'd2, 3'd6, 1'b1);
    for (i = 0; i < 3; i++) begin
      it = random_item(2'd0);
      it.chan = 2'(i % 2);
      it.atten[0] = 11'd0;
      send_item(it);
    end

    // Random part in three phases: a mostly busy sender against a slow
    // receiver, then the reverse, then both flat out with one long receiver
    // hold so the pipeline backs up into the input.
    run_phase(20, 63, 283, 1'b0);
    run_phase(63, 20, 283, 1'b0);
    run_phase(0, 0, 284, 1'b1);

    // Let the last samples out, then allow a little extra time so a stray
    // result would still be caught.
    wait_idle();
    repeat (DRAIN_SLACK) @(posedge clk);
    sb.close_out();

    $display("Covered %0d input transfers, %0d on the unused channel, %0d samples checked.",
             sb.inputs, sb.unused_seen, sb.checked);
    $display("Algorithms %b, feedback depths %b, %0d register settings, one long hold.",
             sb.algs_used, sb.depths_used, cfg_round + 4);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

### fm_four_operator_channel_output.f
design/fm4_pkg.sv
design/fm4_ram.sv
design/fm4_hist.sv
design/fm4_op.sv
design/fm_four_operator_channel_output.sv
sim/fm_four_operator_channel_output_tb.sv
